### rtl/core/mfv_pkg.sv
// shared types, constants and helper functions of the message frame validator
package mfv_pkg;

	// fixed widths of the transaction fields
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned POS_W       = 9;
	localparam int unsigned FIELD_W     = 4;
	localparam int unsigned SLOT_COUNT  = 5;
	localparam int unsigned LIMITS_W    = SLOT_COUNT * BYTE_W;
	localparam int unsigned COUNTS_W    = SLOT_COUNT * FIELD_W;
	localparam int unsigned CFG_DATA_W  = LIMITS_W;
	localparam int unsigned CFG_IDX_W   = 1;

	// header is action, option and size bytes
	localparam logic [POS_W-1:0] HEADER_LEN = 9'd3;

	// byte positions inside the header
	localparam logic [POS_W-1:0] POS_OPTION = 9'd1;
	localparam logic [POS_W-1:0] POS_SIZE   = 9'd2;

	// printable text range and field terminator
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OPTION_LIMITS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNTS  = 1'd1;

	typedef enum logic [2:0] {
		ST_VALID      = 3'd0,
		ST_BAD_ACTION = 3'd1,
		ST_BAD_OPTION = 3'd2,
		ST_BAD_SIZE   = 3'd3,
		ST_BAD_DATA   = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_start;
	} in_item_t;

	typedef struct packed {
		logic               verdict;
		status_t            status;
		logic [BYTE_W-1:0]  action_code;
		logic [BYTE_W-1:0]  option_code;
		logic [POS_W-1:0]   frame_length;
		logic               payload_valid;
		logic [BYTE_W-1:0]  payload_byte;
		logic [FIELD_W-1:0] field_index;
		logic               field_end;
	} out_item_t;

	typedef struct packed {
		logic [POS_W-1:0]   byte_position;
		logic [BYTE_W-1:0]  held_action;
		logic [BYTE_W-1:0]  held_option;
		logic [BYTE_W-1:0]  declared_size;
		logic [FIELD_W-1:0] fields_done;
		logic               frame_decided;
	} frame_state_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} buf_status_t;

	// option limit of an action, zero beyond the packed slots
	function automatic logic [BYTE_W-1:0] option_limit(
		input logic [LIMITS_W-1:0] limits,
		input logic [2:0]          act
	);
		logic [BYTE_W-1:0] lim;
		lim = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (act == 3'(i)) begin
				lim = limits[i*BYTE_W +: BYTE_W];
			end
		end
		return lim;
	endfunction

	// required field count of an action, zero beyond the packed slots
	function automatic logic [FIELD_W-1:0] field_count(
		input logic [COUNTS_W-1:0] counts,
		input logic [2:0]          act
	);
		logic [FIELD_W-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (act == 3'(i)) begin
				cnt = counts[i*FIELD_W +: FIELD_W];
			end
		end
		return cnt;
	endfunction

endpackage

### rtl/core/mfv_in_if.sv
// input byte channel of the message frame validator
interface mfv_in_if;
	logic               valid;
	logic               ready;
	mfv_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/mfv_out_if.sv
// result channel of the message frame validator
interface mfv_out_if;
	logic               valid;
	logic               ready;
	mfv_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/message_frame_validator.sv
// top level of the message frame validator: config, frame state and result buffer
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+---------------------------------------------
//  in_ch    | in  | valid / ready    | frame_byte, frame_start
//  out_ch   | out | valid / ready    | verdict, status, codes, length, payload byte
//  cfg      | in  | cfg_we           | cfg_index, cfg_data (option limits, counts)
//
// One input byte per cycle while in_ch.ready is high, one result transaction per
// byte, buffered on acceptance. The frame check is a single combinational step
// between the held frame state and the result register. A two-deep result buffer
// lets one more byte in while out_ch stalls; in_ch.ready drops only when both
// entries are full. Reset leaves no frame open and clears both registers.
module message_frame_validator #(
	parameter int unsigned ACTION_COUNT = 5,
	parameter int unsigned MAX_FRAME    = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mfv_in_if.sink                             in_ch,
	mfv_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [mfv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [mfv_pkg::LIMITS_W-1:0] option_limits_q;
	logic [mfv_pkg::COUNTS_W-1:0] field_counts_q;
	mfv_pkg::frame_state_t        state_q;
	mfv_pkg::frame_state_t        state_next;
	mfv_pkg::out_item_t           step_result;
	mfv_pkg::buf_status_t         buf_status;
	logic                         can_take;
	logic                         in_accept;

	assign in_ch.ready = can_take;
	assign in_accept   = in_ch.valid && can_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_limits_q <= '0;
			field_counts_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfv_pkg::REG_OPTION_LIMITS: option_limits_q <= cfg_data;
				mfv_pkg::REG_FIELD_COUNTS:  field_counts_q  <= cfg_data[mfv_pkg::COUNTS_W-1:0];
				default: ;
			endcase
		end
	end

	// per-byte check
	mfv_step #(
		.ACTION_COUNT (ACTION_COUNT),
		.MAX_FRAME    (MAX_FRAME)
	) u_step (
		.state         (state_q),
		.item          (in_ch.data),
		.option_limits (option_limits_q),
		.field_counts  (field_counts_q),
		.next_state    (state_next),
		.result        (step_result)
	);

	// frame state, advanced on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{frame_decided: 1'b1, default: '0};
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	// result buffer
	mfv_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (step_result),
		.can_take  (can_take),
		.status    (buf_status),
		.out_ch    (out_ch)
	);

	// skid entry is only ever filled behind a full main entry
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		buf_status.skid_valid |-> buf_status.main_valid)
		else $error("skid entry valid while main entry empty");

	// a verdict closes the frame
	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && step_result.verdict) |=> state_q.frame_decided)
		else $error("frame still open after verdict");

	// frame state moves only on accepted transactions
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> $stable(state_q))
		else $error("frame state changed without a transaction");

	// a nonzero status never appears without a verdict
	a_status_needs_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.data.status != mfv_pkg::ST_VALID)) |-> out_ch.data.verdict)
		else $error("status set without verdict");

endmodule

### rtl/core/mfv_step.sv
// per-byte frame check: next frame state and result from current state and byte
module mfv_step #(
	parameter int unsigned ACTION_COUNT = 5,
	parameter int unsigned MAX_FRAME    = 256
) (
	input  mfv_pkg::frame_state_t            state,
	input  mfv_pkg::in_item_t                item,
	input  logic [mfv_pkg::LIMITS_W-1:0]     option_limits,
	input  logic [mfv_pkg::COUNTS_W-1:0]     field_counts,
	output mfv_pkg::frame_state_t            next_state,
	output mfv_pkg::out_item_t               result
);

	localparam logic [mfv_pkg::POS_W-1:0] MaxFrameLen   = mfv_pkg::POS_W'(MAX_FRAME);
	localparam logic [mfv_pkg::POS_W-1:0] ActionCountLn = mfv_pkg::POS_W'(ACTION_COUNT);

	logic [mfv_pkg::BYTE_W-1:0]  b;
	logic [mfv_pkg::BYTE_W-1:0]  lim;
	logic [mfv_pkg::FIELD_W-1:0] need;
	logic [mfv_pkg::POS_W-1:0]   end_held;
	logic [mfv_pkg::POS_W-1:0]   end_new;
	logic [mfv_pkg::POS_W-1:0]   sum_held;
	logic [mfv_pkg::POS_W-1:0]   sum_new;
	logic [mfv_pkg::POS_W-1:0]   pos_inc;
	logic [mfv_pkg::FIELD_W-1:0] fields_inc;
	logic                        is_text;

	// per-action limits and frame end bounds
	always_comb begin
		b          = item.frame_byte;
		lim        = mfv_pkg::option_limit(option_limits, state.held_action[2:0]);
		need       = mfv_pkg::field_count(field_counts, state.held_action[2:0]);
		sum_held   = {1'b0, state.declared_size} + mfv_pkg::HEADER_LEN;
		end_held   = (sum_held > MaxFrameLen) ? MaxFrameLen : sum_held;
		sum_new    = {1'b0, b} + mfv_pkg::HEADER_LEN;
		end_new    = (sum_new > MaxFrameLen) ? MaxFrameLen : sum_new;
		pos_inc    = state.byte_position + 9'd1;
		fields_inc = state.fields_done + 4'd1;
		is_text    = (b >= mfv_pkg::CHAR_SPACE) && (b <= mfv_pkg::CHAR_TILDE);
	end

	// frame walk
	always_comb begin
		next_state = state;
		result     = '0;
		if (item.frame_start) begin
			next_state.held_action   = b;
			next_state.held_option   = '0;
			next_state.declared_size = '0;
			next_state.fields_done   = '0;
			next_state.byte_position = mfv_pkg::POS_OPTION;
			next_state.frame_decided = 1'b0;
			if ({1'b0, b} >= ActionCountLn) begin
				result.verdict           = 1'b1;
				result.status            = mfv_pkg::ST_BAD_ACTION;
				next_state.frame_decided = 1'b1;
			end
		end else if (!state.frame_decided) begin
			case (state.byte_position)
				mfv_pkg::POS_OPTION: begin
					next_state.held_option = b;
					if (b > lim) begin
						result.verdict           = 1'b1;
						result.status            = mfv_pkg::ST_BAD_OPTION;
						next_state.frame_decided = 1'b1;
					end else begin
						next_state.byte_position = mfv_pkg::POS_SIZE;
					end
				end
				mfv_pkg::POS_SIZE: begin
					next_state.declared_size = b;
					if (need == '0) begin
						// action with no fields: size byte decides
						result.verdict           = 1'b1;
						next_state.frame_decided = 1'b1;
						if (b != '0) begin
							result.status = mfv_pkg::ST_BAD_SIZE;
						end else begin
							result.status       = mfv_pkg::ST_VALID;
							result.frame_length = mfv_pkg::HEADER_LEN;
						end
					end else begin
						next_state.byte_position = mfv_pkg::HEADER_LEN;
						if (mfv_pkg::HEADER_LEN >= end_new) begin
							result.verdict           = 1'b1;
							result.status            = mfv_pkg::ST_BAD_SIZE;
							next_state.frame_decided = 1'b1;
						end
					end
				end
				default: begin
					// text field bytes
					if (b == mfv_pkg::CHAR_NUL) begin
						result.payload_valid   = 1'b1;
						result.field_index     = state.fields_done;
						result.field_end       = 1'b1;
						next_state.fields_done = fields_inc;
						if (fields_inc == need) begin
							result.verdict           = 1'b1;
							result.status            = mfv_pkg::ST_VALID;
							result.frame_length      = sum_held;
							next_state.frame_decided = 1'b1;
						end
					end else if (is_text) begin
						result.payload_valid = 1'b1;
						result.payload_byte  = b;
						result.field_index   = state.fields_done;
					end else begin
						result.verdict           = 1'b1;
						result.status            = mfv_pkg::ST_BAD_DATA;
						next_state.frame_decided = 1'b1;
					end
					// out of room
					if (!next_state.frame_decided) begin
						next_state.byte_position = pos_inc;
						if (pos_inc >= end_held) begin
							result.verdict           = 1'b1;
							result.status            = mfv_pkg::ST_BAD_SIZE;
							next_state.frame_decided = 1'b1;
						end
					end
				end
			endcase
		end
		result.action_code = next_state.held_action;
		result.option_code = next_state.held_option;
	end

endmodule

### rtl/core/mfv_out_buf.sv
// result register with a skid stage so input can take one more byte under output stall
module mfv_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mfv_pkg::out_item_t     push_data,
	output logic                   can_take,
	output mfv_pkg::buf_status_t   status,
	mfv_out_if.source              out_ch
);

	logic               main_valid_q;
	logic               skid_valid_q;
	mfv_pkg::out_item_t main_q;
	mfv_pkg::out_item_t skid_q;
	logic               pop;

	assign pop               = main_valid_q && out_ch.ready;
	assign can_take          = !skid_valid_q;
	assign out_ch.valid      = main_valid_q;
	assign out_ch.data       = main_q;
	assign status.main_valid = main_valid_q;
	assign status.skid_valid = skid_valid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
